// ===== hdl/wavetable_lfo_assert.svh =====
// Assertion macros for the wavetable LFO.
// Used by wavetable_lfo.sv; empty bodies when SYNTHESIS is defined.
`ifndef WAVETABLE_LFO_ASSERT_SVH
`define WAVETABLE_LFO_ASSERT_SVH
`ifndef SYNTHESIS
`define WLFO_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("wavetable_lfo: same-cycle check failed");
`define WLFO_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wavetable_lfo: next-cycle check failed");
`else
`define WLFO_ASSERT_SAME(label, clk, rstn, ante, cons)
`define WLFO_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== hdl/wlfo_pkg.sv =====
// Package for the wavetable LFO: table geometry, register and mode codes,
// fixed-point constants and the pipeline sideband type. No dependencies.
`timescale 1ns / 1ps

package wlfo_pkg;

    localparam int TABLE_SIZE = 1024;
    localparam int TABLE_BITS = $clog2(TABLE_SIZE);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int MS_W        = 32;
    localparam int FREQ_W      = 32;
    localparam int PW_W        = 17;
    localparam int SAMPLE_W    = 16;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ACTIVE       = 3'd0,
        REG_MODE         = 3'd1,
        REG_FREQ         = 3'd2,
        REG_PULSE_WIDTH  = 3'd3,
        REG_START_OFFSET = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MODE_SINE     = 3'd0,
        MODE_COSINE   = 3'd1,
        MODE_SQUARE   = 3'd2,
        MODE_IMPULSE  = 3'd3,
        MODE_TRIANGLE = 3'd4
    } mode_t;

    // (x mod 1000) of a 48-bit value from its 16-bit chunks
    localparam logic [9:0] MOD_C1 = 10'd536;  // 2^16 mod 1000
    localparam logic [9:0] MOD_C2 = 10'd296;  // 2^32 mod 1000
    localparam int         SUM_W  = 26;

    // floor(v / 1000) = (v * RECIP_M) >> RECIP_SH, exact for v < 2^26
    localparam logic [26:0] RECIP_M  = 27'd68719477;
    localparam int          RECIP_SH = 36;
    localparam logic [9:0]  MS_PER_S = 10'd1000;

    localparam logic [15:0] ONE_Q15 = 16'd32767;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam logic [30:0] COEF_1 = 31'd1686629713;
    localparam logic [30:0] COEF_3 = 31'd693598668;
    localparam logic [30:0] COEF_5 = 31'd85569306;
    localparam logic [30:0] COEF_7 = 31'd5026994;
    localparam logic [30:0] COEF_9 = 31'd172273;

    typedef struct packed {
        logic [TABLE_BITS-1:0] idx;
        logic                  use_sine;
        logic                  neg;
        logic [SAMPLE_W-1:0]   other;
    } meta_t;

endpackage

// ===== hdl/wavetable_lfo.sv =====
// Wavetable LFO top level: index math, phase state and waveform pipeline.
// Depends on wlfo_pkg and wavetable_lfo_assert.svh.
`timescale 1ns / 1ps
//
// Usage:
//   Input words: s_tuser = func (0 sample request, 1 retrigger),
//   s_tdata = elapsed_ms. Each sample request yields one output word,
//   m_tdata = {table_index, sample}; a retrigger yields none and loads
//   the current offset from the last phase.
//   Configuration: cfg_we/cfg_index/cfg_wdata, written while idle.
//   Pipeline of 15 stages from the accepting edge to m_tvalid; one word
//   per cycle sustained while m_tready is high. The depth is set by the
//   32x32 multiply of the product, the mod-1000 folding, the two
//   divide-by-1000 reciprocals and the five steps of the sine polynomial.
//   Phase state is updated in stage 6, in input order.
//   A stalled receiver holds the output register; stages behind it keep
//   filling bubbles, and s_tready falls only when every stage is full.
//   Reset (aresetn low, synchronous) empties the pipeline and restores the
//   register defaults: active, sine, 1 Hz, half pulse width, offset 0.
//
`include "wavetable_lfo_assert.svh"

module wavetable_lfo (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [wlfo_pkg::S_DATA_W-1:0]    s_tdata,   // [31:0] elapsed_ms
    input  logic                             s_tuser,   // [0] func
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wlfo_pkg::M_DATA_W-1:0]    m_tdata,   // [15:0] sample, [25:16] table_index
    input  logic                             cfg_we,
    input  logic [wlfo_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wlfo_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int NUM_STAGES = 15;
    localparam int OFS_STAGE  = 6;
    localparam int TB         = wlfo_pkg::TABLE_BITS;
    localparam int FRAC_W     = TB - 2;
    localparam int NUM_W      = 10 + TB;

    // control
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] rdy;

    logic                          active_reg;
    logic [2:0]                    mode_reg;
    logic [wlfo_pkg::FREQ_W-1:0]   freq_reg;
    logic [wlfo_pkg::PW_W-1:0]     pw_reg;
    logic [TB-1:0]                 cur_off_reg;
    logic [TB-1:0]                 last_phase_reg;

    // payload
    logic                          func_reg [0:5];
    logic [wlfo_pkg::MS_W-1:0]     ms_reg;
    logic [63:0]                   prod_reg;
    logic [wlfo_pkg::SUM_W-1:0]    sum_reg [2:3];
    logic [TB-1:0]                 lo_reg [2:4];
    logic [15:0]                   qq_reg;
    logic [9:0]                    rem_reg;
    logic [TB-1:0]                 raw_reg;
    logic [TB-1:0]                 ofs_idx_reg;
    logic                          blank_reg;
    wlfo_pkg::meta_t               meta_reg [7:13];
    logic [30:0]                   x_reg [7:12];
    logic [30:0]                   x2_reg [8:11];
    logic [30:0]                   poly_reg [9:12];
    logic [30:0]                   s_reg;
    logic [wlfo_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic [TB-1:0]                 out_index_reg;

    // next values
    logic [63:0]                   prod_next;
    logic [wlfo_pkg::SUM_W-1:0]    sum_next;
    logic [52:0]                   recip_a;
    logic [15:0]                   qq_next;
    logic [wlfo_pkg::SUM_W-1:0]    qm;
    logic [wlfo_pkg::SUM_W-1:0]    rem_full;
    logic [9:0]                    rem_next;
    logic [NUM_W-1:0]              num;
    logic [NUM_W+26:0]             recip_b;
    logic [TB-1:0]                 raw_next;
    logic [TB-1:0]                 ofs_idx_next;
    logic [1:0]                    quad;
    logic [30:0]                   xf;
    logic [30:0]                   x_next;
    logic [TB:0]                   tri_d;
    logic [TB+15:0]                tri_prod;
    logic [wlfo_pkg::SAMPLE_W-1:0] other_wave;
    wlfo_pkg::meta_t               meta_next;
    logic [61:0]                   sq_prod;
    logic [61:0]                   c9_prod;
    logic [61:0]                   step_prod [10:12];
    logic [30:0]                   poly_next [9:12];
    logic [61:0]                   s_prod;
    logic [45:0]                   scale_prod;
    logic [15:0]                   mag_raw;
    logic [wlfo_pkg::SAMPLE_W-1:0] mag;
    logic [wlfo_pkg::SAMPLE_W-1:0] sine_val;
    logic [wlfo_pkg::SAMPLE_W-1:0] sample_next;
    logic                          square_hi;

    // handshake: a stage loads when it is empty or the stage ahead loads
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_rdy
        assign rdy[k] = m_tready | ~(&vld_reg[NUM_STAGES-1:k]);
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = {{(wlfo_pkg::M_DATA_W - wlfo_pkg::SAMPLE_W - TB){1'b0}},
                       out_index_reg, out_sample_reg};

    // index math
    assign prod_next = 64'(ms_reg) * 64'(freq_reg);
    assign sum_next  = wlfo_pkg::SUM_W'(prod_reg[31:16])
                     + wlfo_pkg::SUM_W'(prod_reg[47:32]) * wlfo_pkg::SUM_W'(wlfo_pkg::MOD_C1)
                     + wlfo_pkg::SUM_W'(prod_reg[63:48]) * wlfo_pkg::SUM_W'(wlfo_pkg::MOD_C2);
    assign recip_a   = 53'(sum_reg[2]) * 53'(wlfo_pkg::RECIP_M);
    assign qq_next   = recip_a[wlfo_pkg::RECIP_SH+15:wlfo_pkg::RECIP_SH];
    assign qm        = wlfo_pkg::SUM_W'(qq_reg) * wlfo_pkg::SUM_W'(wlfo_pkg::MS_PER_S);
    assign rem_full  = sum_reg[3] - qm;
    assign rem_next  = rem_full[9:0];
    assign num       = {rem_reg, lo_reg[4]};
    assign recip_b   = (NUM_W+27)'(num) * (NUM_W+27)'(wlfo_pkg::RECIP_M);
    assign raw_next  = recip_b[wlfo_pkg::RECIP_SH+TB-1:wlfo_pkg::RECIP_SH];
    assign ofs_idx_next = active_reg ? raw_reg + cur_off_reg : '0;

    // waveform select
    assign quad = ofs_idx_reg[TB-1:TB-2]
                + ((mode_reg == wlfo_pkg::MODE_COSINE) ? 2'd1 : 2'd0);
    assign xf     = {1'b0, ofs_idx_reg[FRAC_W-1:0], {(30-FRAC_W){1'b0}}};
    assign x_next = quad[0] ? wlfo_pkg::ONE_Q30 - xf : xf;

    assign tri_d     = ofs_idx_reg[TB-1] ? (TB+1)'(wlfo_pkg::TABLE_SIZE) - (TB+1)'(ofs_idx_reg)
                                         : (TB+1)'(ofs_idx_reg);
    assign tri_prod  = (TB+16)'(tri_d) * (TB+16)'(wlfo_pkg::ONE_Q15);
    assign square_hi = wlfo_pkg::PW_W'({ofs_idx_reg, {(16-TB){1'b0}}}) < pw_reg;

    always_comb begin
        case (mode_reg)
            wlfo_pkg::MODE_SQUARE:   other_wave = square_hi ? wlfo_pkg::ONE_Q15 : '0;
            wlfo_pkg::MODE_IMPULSE:  other_wave = (ofs_idx_reg == '0) ? wlfo_pkg::ONE_Q15 : '0;
            wlfo_pkg::MODE_TRIANGLE: other_wave = tri_prod[TB+14:TB-1];
            default:                 other_wave = '0;
        endcase
        meta_next.idx      = ofs_idx_reg;
        meta_next.use_sine = !blank_reg && (mode_reg == wlfo_pkg::MODE_SINE
                                            || mode_reg == wlfo_pkg::MODE_COSINE);
        meta_next.neg      = quad[1];
        meta_next.other    = blank_reg ? '0 : other_wave;
    end

    // quarter-wave polynomial, Horner form in Q1.30
    assign sq_prod      = 62'(x_reg[7]) * 62'(x_reg[7]);
    assign c9_prod      = 62'(x2_reg[8]) * 62'(wlfo_pkg::COEF_9);
    assign poly_next[9] = wlfo_pkg::COEF_7 - c9_prod[60:30];
    assign step_prod[10] = 62'(x2_reg[9])  * 62'(poly_reg[9]);
    assign step_prod[11] = 62'(x2_reg[10]) * 62'(poly_reg[10]);
    assign step_prod[12] = 62'(x2_reg[11]) * 62'(poly_reg[11]);
    assign poly_next[10] = wlfo_pkg::COEF_5 - step_prod[10][60:30];
    assign poly_next[11] = wlfo_pkg::COEF_3 - step_prod[11][60:30];
    assign poly_next[12] = wlfo_pkg::COEF_1 - step_prod[12][60:30];
    assign s_prod       = 62'(x_reg[12]) * 62'(poly_reg[12]);

    assign scale_prod  = 46'(s_reg) * 46'(wlfo_pkg::ONE_Q15) + 46'(64'd1 << 29);
    assign mag_raw     = scale_prod[45:30];
    assign mag         = (mag_raw > wlfo_pkg::ONE_Q15) ? wlfo_pkg::ONE_Q15 : mag_raw;
    assign sine_val    = meta_reg[13].neg ? 16'(-mag) : mag;
    assign sample_next = meta_reg[13].use_sine ? sine_val : meta_reg[13].other;

    // control and phase state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg        <= '0;
            active_reg     <= 1'b1;
            mode_reg       <= wlfo_pkg::MODE_SINE;
            freq_reg       <= 32'd65536;
            pw_reg         <= 17'd32768;
            cur_off_reg    <= '0;
            last_phase_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (rdy[k] && k != OFS_STAGE) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (rdy[OFS_STAGE]) begin
                vld_reg[OFS_STAGE] <= vld_reg[OFS_STAGE-1] && !func_reg[5];
                if (vld_reg[OFS_STAGE-1] && func_reg[5]) begin
                    cur_off_reg <= last_phase_reg;
                end else if (vld_reg[OFS_STAGE-1] && active_reg) begin
                    last_phase_reg <= ofs_idx_next;
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    wlfo_pkg::REG_ACTIVE:       active_reg <= cfg_wdata[0];
                    wlfo_pkg::REG_MODE:         mode_reg   <= cfg_wdata[2:0];
                    wlfo_pkg::REG_FREQ:         freq_reg   <= cfg_wdata;
                    wlfo_pkg::REG_PULSE_WIDTH:  pw_reg     <= cfg_wdata[wlfo_pkg::PW_W-1:0];
                    wlfo_pkg::REG_START_OFFSET: cur_off_reg <= cfg_wdata[TB-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            func_reg[0] <= s_tuser;
            ms_reg      <= s_tdata;
        end
        for (int k = 1; k <= 5; k++) begin
            if (rdy[k]) begin
                func_reg[k] <= func_reg[k-1];
            end
        end
        if (rdy[1]) prod_reg <= prod_next;
        if (rdy[2]) begin
            sum_reg[2] <= sum_next;
            lo_reg[2]  <= prod_reg[15:16-TB];
        end
        if (rdy[3]) begin
            sum_reg[3] <= sum_reg[2];
            lo_reg[3]  <= lo_reg[2];
            qq_reg     <= qq_next;
        end
        if (rdy[4]) begin
            lo_reg[4] <= lo_reg[3];
            rem_reg   <= rem_next;
        end
        if (rdy[5]) raw_reg <= raw_next;
        if (rdy[6]) begin
            ofs_idx_reg <= ofs_idx_next;
            blank_reg   <= !active_reg;
        end
        if (rdy[7]) begin
            meta_reg[7] <= meta_next;
            x_reg[7]    <= x_next;
        end
        for (int k = 8; k <= 13; k++) begin
            if (rdy[k]) begin
                meta_reg[k] <= meta_reg[k-1];
            end
        end
        for (int k = 8; k <= 12; k++) begin
            if (rdy[k]) begin
                x_reg[k] <= x_reg[k-1];
            end
        end
        if (rdy[8]) x2_reg[8] <= sq_prod[60:30];
        for (int k = 9; k <= 11; k++) begin
            if (rdy[k]) begin
                x2_reg[k] <= x2_reg[k-1];
            end
        end
        for (int k = 9; k <= 12; k++) begin
            if (rdy[k]) begin
                poly_reg[k] <= poly_next[k];
            end
        end
        if (rdy[13]) s_reg <= s_prod[60:30];
        if (rdy[14]) begin
            out_sample_reg <= sample_next;
            out_index_reg  <= meta_reg[13].idx;
        end
    end

    `WLFO_ASSERT_NEXT(a_retrig_drop, aclk, aresetn, vld_reg[5] && func_reg[5] && rdy[6], !vld_reg[6])
    `WLFO_ASSERT_NEXT(a_retrig_off, aclk, aresetn, vld_reg[5] && func_reg[5] && rdy[6] && !cfg_we, cur_off_reg == $past(last_phase_reg))
    `WLFO_ASSERT_NEXT(a_phase_track, aclk, aresetn, vld_reg[5] && !func_reg[5] && active_reg && rdy[6], last_phase_reg == ofs_idx_reg)
    `WLFO_ASSERT_SAME(a_stall_full, aclk, aresetn, !s_tready, m_tvalid && !m_tready)

endmodule
